// ===== rtl/tch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tch_pkg
// Constants for the tilt-compensated heading pipeline: word widths, CORDIC
// depth, fixed-point angle constants and the arctangent table.
// ----------------------------------------------------------------------------
package tch_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;

    // Rotation CORDIC: angle residue in Q3.29 and x/y in Q1.30.
    localparam int ZW = 34;
    localparam int RW = 34;
    // Sine and cosine after folding, Q1.30.
    localparam int SW = 32;
    // Vectoring CORDIC: x/y in counts Q30, angle residue Q3.29.
    localparam int VW  = 52;
    localparam int VZW = 35;
    // Rounded heading before the final wrap.
    localparam int HW = 19;

    localparam logic signed [RW-1:0]  GAIN_INV_Q30 = 34'sd652032874;
    localparam logic signed [ZW-1:0]  PI_Q29       = 34'sd1686629713;
    localparam logic signed [ZW-1:0]  HALF_PI_Q29  = 34'sd843314857;
    localparam logic signed [VZW-1:0] PI_Q29_V     = 35'sd1686629713;
    localparam logic signed [VZW-1:0] TWO_PI_Q29   = 35'sd3373259426;
    localparam logic [HW-1:0]         TWO_PI_Q13   = 19'd51472;
    localparam logic signed [VZW-1:0] ROUND_HALF   = 35'sd32768;

    localparam logic [31:0] ATAN_Q29 [0:TABLE_LEN-1] = '{
        32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579,
        32'd33510843,  32'd16771758,  32'd8387925,   32'd4194219,
        32'd2097141,   32'd1048575,   32'd524288,    32'd262144,
        32'd131072,    32'd65536,     32'd32768,     32'd16384,
        32'd8192,      32'd4096,      32'd2048,      32'd1024,
        32'd512,       32'd256,       32'd128,       32'd64
    };

endpackage

// ===== rtl/tilt_compensated_heading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_heading
// Tilt-compensated compass heading from roll, pitch and a magnetometer sample.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; every CORDIC iteration and every product
// has a pipeline register of its own, and the whole pipe stalls together.
// Reset: aresetn, synchronous and active low, clears every stage valid bit;
// the data registers are not reset.
module tilt_compensated_heading
    import tch_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // roll_angle[15:0], pitch_angle[31:16], field_x[47:32],
    // field_y[63:48], field_z[79:64]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // heading_angle[15:0]
    output logic [15:0] m_tdata
);

    localparam int N = CORDIC_STAGES;

    // The whole pipe moves as one whenever the output register is free or
    // being emptied. Bubbles travel with their valid bit cleared.
    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // ------------------------------------------------------------------
    // Rotation CORDIC for roll and pitch, stage 0 is the folding stage.
    // ------------------------------------------------------------------
    logic                 rot_vld_reg [0:N];
    logic signed [ZW-1:0] zr_reg [0:N];
    logic signed [ZW-1:0] zp_reg [0:N];
    logic signed [RW-1:0] xr_reg [0:N];
    logic signed [RW-1:0] yr_reg [0:N];
    logic signed [RW-1:0] xp_reg [0:N];
    logic signed [RW-1:0] yp_reg [0:N];
    logic                 flr_reg [0:N];
    logic                 flp_reg [0:N];
    logic signed [15:0]   mx_reg [0:N];
    logic signed [15:0]   my_reg [0:N];
    logic signed [15:0]   mz_reg [0:N];

    logic signed [ZW-1:0] zr_in, zp_in, zr_next, zp_next;
    logic                 flr_next, flp_next;

    always_comb begin
        zr_in = ZW'($signed(s_tdata[15:0])) <<< 16;
        zp_in = ZW'($signed(s_tdata[31:16])) <<< 16;
        // Angles past a right angle are moved by pi towards zero, and the
        // sine and cosine are negated once the rotation is done.
        flr_next = 1'b0;
        zr_next  = zr_in;
        if (zr_in > HALF_PI_Q29) begin
            zr_next  = zr_in - PI_Q29;
            flr_next = 1'b1;
        end else if (zr_in < -HALF_PI_Q29) begin
            zr_next  = zr_in + PI_Q29;
            flr_next = 1'b1;
        end
        flp_next = 1'b0;
        zp_next  = zp_in;
        if (zp_in > HALF_PI_Q29) begin
            zp_next  = zp_in - PI_Q29;
            flp_next = 1'b1;
        end else if (zp_in < -HALF_PI_Q29) begin
            zp_next  = zp_in + PI_Q29;
            flp_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= N; k++) begin
                rot_vld_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            rot_vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= N; k++) begin
                rot_vld_reg[k] <= rot_vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            zr_reg[0]  <= zr_next;
            zp_reg[0]  <= zp_next;
            flr_reg[0] <= flr_next;
            flp_reg[0] <= flp_next;
            xr_reg[0]  <= GAIN_INV_Q30;
            yr_reg[0]  <= '0;
            xp_reg[0]  <= GAIN_INV_Q30;
            yp_reg[0]  <= '0;
            mx_reg[0]  <= $signed(s_tdata[47:32]);
            my_reg[0]  <= $signed(s_tdata[63:48]);
            mz_reg[0]  <= $signed(s_tdata[79:64]);
            for (int k = 1; k <= N; k++) begin
                flr_reg[k] <= flr_reg[k-1];
                flp_reg[k] <= flp_reg[k-1];
                mx_reg[k]  <= mx_reg[k-1];
                my_reg[k]  <= my_reg[k-1];
                mz_reg[k]  <= mz_reg[k-1];
                if (zr_reg[k-1] >= 0) begin
                    xr_reg[k] <= xr_reg[k-1] - (yr_reg[k-1] >>> (k-1));
                    yr_reg[k] <= yr_reg[k-1] + (xr_reg[k-1] >>> (k-1));
                    zr_reg[k] <= zr_reg[k-1] - $signed({2'b00, ATAN_Q29[k-1]});
                end else begin
                    xr_reg[k] <= xr_reg[k-1] + (yr_reg[k-1] >>> (k-1));
                    yr_reg[k] <= yr_reg[k-1] - (xr_reg[k-1] >>> (k-1));
                    zr_reg[k] <= zr_reg[k-1] + $signed({2'b00, ATAN_Q29[k-1]});
                end
                if (zp_reg[k-1] >= 0) begin
                    xp_reg[k] <= xp_reg[k-1] - (yp_reg[k-1] >>> (k-1));
                    yp_reg[k] <= yp_reg[k-1] + (xp_reg[k-1] >>> (k-1));
                    zp_reg[k] <= zp_reg[k-1] - $signed({2'b00, ATAN_Q29[k-1]});
                end else begin
                    xp_reg[k] <= xp_reg[k-1] + (yp_reg[k-1] >>> (k-1));
                    yp_reg[k] <= yp_reg[k-1] - (xp_reg[k-1] >>> (k-1));
                    zp_reg[k] <= zp_reg[k-1] + $signed({2'b00, ATAN_Q29[k-1]});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Unfold the sines and cosines, then form the horizontal components.
    // ------------------------------------------------------------------
    logic                 m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg;
    logic signed [SW-1:0] sr_reg, cr_reg, sp_reg, cp_reg;
    logic signed [15:0]   m1_mx_reg, m1_my_reg, m1_mz_reg;
    logic signed [15:0]   m2_my_reg, m2_mz_reg;
    logic signed [63:0]   pss_reg, psc_reg;
    logic signed [47:0]   ta1_reg, ta2_reg, tb1_reg;
    logic signed [49:0]   p1_reg, p2_reg;
    logic signed [48:0]   a3_reg;
    logic signed [47:0]   tb1_m3_reg;
    logic signed [VW-1:0] a_reg, b_reg;

    logic signed [RW-1:0] sr_next, cr_next, sp_next, cp_next;
    logic signed [33:0]   pss_sh, psc_sh;

    always_comb begin
        sr_next = flr_reg[N] ? -yr_reg[N] : yr_reg[N];
        cr_next = flr_reg[N] ? -xr_reg[N] : xr_reg[N];
        sp_next = flp_reg[N] ? -yp_reg[N] : yp_reg[N];
        cp_next = flp_reg[N] ? -xp_reg[N] : xp_reg[N];
        pss_sh  = 34'(pss_reg >>> 30);
        psc_sh  = 34'(psc_reg >>> 30);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
        end else if (advance) begin
            m1_vld_reg <= rot_vld_reg[N];
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sr_reg    <= SW'(sr_next);
            cr_reg    <= SW'(cr_next);
            sp_reg    <= SW'(sp_next);
            cp_reg    <= SW'(cp_next);
            m1_mx_reg <= mx_reg[N];
            m1_my_reg <= my_reg[N];
            m1_mz_reg <= mz_reg[N];

            pss_reg   <= sp_reg * sr_reg;
            psc_reg   <= sp_reg * cr_reg;
            ta1_reg   <= m1_my_reg * cr_reg;
            ta2_reg   <= m1_mz_reg * sr_reg;
            tb1_reg   <= m1_mx_reg * cp_reg;
            m2_my_reg <= m1_my_reg;
            m2_mz_reg <= m1_mz_reg;

            p1_reg     <= m2_my_reg * pss_sh;
            p2_reg     <= m2_mz_reg * psc_sh;
            a3_reg     <= 49'(ta1_reg) + 49'(ta2_reg);
            tb1_m3_reg <= tb1_reg;

            a_reg <= VW'(a3_reg);
            b_reg <= VW'(tb1_m3_reg) + VW'(p1_reg) - VW'(p2_reg);
        end
    end

    // ------------------------------------------------------------------
    // Vectoring CORDIC on (b, -a); stage 0 folds the left half plane.
    // ------------------------------------------------------------------
    logic                  vec_vld_reg [0:N];
    logic signed [VW-1:0]  vx_reg [0:N];
    logic signed [VW-1:0]  vy_reg [0:N];
    logic signed [VZW-1:0] vz_reg [0:N];
    logic                  zero_reg [0:N];

    logic signed [VW-1:0]  vy_in;

    assign vy_in = -a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= N; k++) begin
                vec_vld_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            vec_vld_reg[0] <= m4_vld_reg;
            for (int k = 1; k <= N; k++) begin
                vec_vld_reg[k] <= vec_vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            zero_reg[0] <= (a_reg == '0) && (b_reg == '0);
            if (b_reg < 0) begin
                vx_reg[0] <= -b_reg;
                vy_reg[0] <= -vy_in;
                vz_reg[0] <= (vy_in >= 0) ? PI_Q29_V : -PI_Q29_V;
            end else begin
                vx_reg[0] <= b_reg;
                vy_reg[0] <= vy_in;
                vz_reg[0] <= '0;
            end
            for (int k = 1; k <= N; k++) begin
                zero_reg[k] <= zero_reg[k-1];
                if (vy_reg[k-1] >= 0) begin
                    vx_reg[k] <= vx_reg[k-1] + (vy_reg[k-1] >>> (k-1));
                    vy_reg[k] <= vy_reg[k-1] - (vx_reg[k-1] >>> (k-1));
                    vz_reg[k] <= vz_reg[k-1] + $signed({3'b000, ATAN_Q29[k-1]});
                end else begin
                    vx_reg[k] <= vx_reg[k-1] - (vy_reg[k-1] >>> (k-1));
                    vy_reg[k] <= vy_reg[k-1] + (vx_reg[k-1] >>> (k-1));
                    vz_reg[k] <= vz_reg[k-1] - $signed({3'b000, ATAN_Q29[k-1]});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Wrap into [0, 2*pi), round to Q3.13 and hold in the output register.
    // ------------------------------------------------------------------
    logic                  f1_vld_reg, out_vld_reg;
    logic signed [VZW-1:0] zw_reg;
    logic                  f1_zero_reg;
    logic [15:0]           heading_reg;

    logic signed [VZW-1:0] zr_round;
    logic signed [HW-1:0]  r_full;
    logic [15:0]           heading_next;

    always_comb begin
        zr_round = zw_reg + ROUND_HALF;
        r_full   = HW'(zr_round >>> 16);
        if (f1_zero_reg || r_full < 0) begin
            heading_next = '0;
        end else if ($unsigned(r_full) >= TWO_PI_Q13) begin
            heading_next = 16'($unsigned(r_full) - TWO_PI_Q13);
        end else begin
            heading_next = 16'($unsigned(r_full));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            f1_vld_reg  <= vec_vld_reg[N];
            out_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            f1_zero_reg <= zero_reg[N];
            zw_reg      <= (vz_reg[N] < 0) ? vz_reg[N] + TWO_PI_Q29 : vz_reg[N];
            heading_reg <= heading_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = heading_reg;

endmodule

// ===== tb/sv/tilt_compensated_heading_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_heading_test
// Self-checking bench for the tilt-compensated heading pipeline. Every
// accepted request is run through an integer CORDIC predictor in the bench.
// Each heading that the block returns is compared in order with the oldest
// prediction. The stimulus is a directed set of corner angles and fields,
// then random samples with random gaps on both sides. There is also one long
// output stall, a drain pause, and a final part with no idling.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_test;
    import tch_pkg::*;

    // Fixed-point constants of the heading arithmetic (Q1.30, Q3.29 and Q3.13).
    localparam longint ROT_GAIN   = 64'sd652032874;
    localparam longint ANG_PI     = 64'sd1686629713;
    localparam longint ANG_HALFPI = 64'sd843314857;
    localparam longint ANG_TWOPI  = 64'sd3373259426;
    localparam longint FULL_TURN  = 64'sd51472;
    localparam int     RUN_LIMIT  = 200000;
    localparam int     TAIL_WAIT  = 2 * CORDIC_STAGES + 40;

    typedef struct packed {
        logic signed [15:0] fz;
        logic signed [15:0] fy;
        logic signed [15:0] fx;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [15:0] heading_due[$];
    int          errors = 0;
    int          cycles = 0;
    int          results_seen = 0;
    // Random idling switches for the sender and the receiver.
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    // A long receiver hold-off, counted down in the receiver process.
    int          rx_hold = 0;

    tilt_compensated_heading dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Heading predictor: rotation CORDIC for sine and cosine, vectoring
    // CORDIC for the arctangent. Every shift is an arithmetic (floor) shift.
    // ------------------------------------------------------------------------
    function automatic void rotate_angle(input logic signed [15:0] ang,
                                         output longint s, output longint c);
        longint z, x, y, t;
        bit     flip;
        z = longint'(ang) * 65536;
        x = ROT_GAIN;
        y = 0;
        flip = 1'b0;
        // Angles past a quarter turn are folded by half a turn, and the
        // signs are put back afterwards.
        if (z > ANG_HALFPI) begin
            z = z - ANG_PI;
            flip = 1'b1;
        end else if (z < -ANG_HALFPI) begin
            z = z + ANG_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_Q29[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_Q29[i]);
            end
            x = t;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t;
        z = 0;
        // In the left half plane the vector is turned by half a turn first.
        if (x < 0) begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
            if (y >= 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_Q29[i]);
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_Q29[i]);
            end
            x = t;
        end
        return z;
    endfunction

    function automatic logic [15:0] predict_heading(sample_t smp);
        longint sr, cr, sp, cp, a, b, z, r;
        rotate_angle(smp.roll, sr, cr);
        rotate_angle(smp.pitch, sp, cp);
        a = longint'(smp.fy) * cr + longint'(smp.fz) * sr;
        b = longint'(smp.fx) * cp + longint'(smp.fy) * ((sp * sr) >>> 30)
            - longint'(smp.fz) * ((sp * cr) >>> 30);
        // A field with no horizontal part gives a heading of zero.
        if (a == 0 && b == 0) begin
            r = 0;
        end else begin
            z = vector_angle(-a, b);
            if (z < 0) begin
                z = z + ANG_TWOPI;
            end
            r = (z + 32768) >>> 16;
            // Rounding up to a full turn wraps round to zero.
            if (r >= FULL_TURN) begin
                r = r - FULL_TURN;
            end
            if (r < 0) begin
                r = 0;
            end
        end
        return r[15:0];
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers one request and holds it until the block takes it. The
    // ready line is sampled at the falling edge, where it is settled.
    // ------------------------------------------------------------------------
    task automatic send_sample(sample_t smp);
        bit taken;
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
        heading_due.push_back(predict_heading(smp));
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom());
            1:       return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
            default: return 16'(int'($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 11))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3:       return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t smp;
        smp.roll  = rand_angle();
        smp.pitch = rand_angle();
        smp.fx    = rand_field();
        smp.fy    = rand_field();
        smp.fz    = rand_field();
        return smp;
    endfunction

    task automatic wait_drained();
        while (heading_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Corner angles: zero, plus and minus pi, either side of the quarter-turn
    // fold, and 16-bit patterns beyond pi. Fields: full scale both ways, and
    // plus and minus one.
    task automatic test_corner_samples();
        logic signed [15:0] angs [8];
        logic signed [15:0] flds [4];
        sample_t smp;
        angs = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12867, 16'sd12868,
                 -16'sd12868, 16'sh7fff, 16'sh8000};
        flds = '{16'sh7fff, 16'sh8000, 16'sd1, -16'sd1};
        for (int i = 0; i < 8; i++) begin
            smp = '{fz: flds[i % 4], fy: flds[(i + 1) % 4], fx: flds[(i + 2) % 4],
                    pitch: angs[7 - i], roll: angs[i]};
            send_sample(smp);
        end
        // Every field zero, and a field along one axis at a time.
        send_sample('{fz: 0, fy: 0, fx: 0, pitch: 16'sd5000, roll: -16'sd3000});
        send_sample('{fz: 0, fy: 0, fx: 16'sh7fff, pitch: 0, roll: 0});
        send_sample('{fz: 0, fy: 0, fx: 16'sh8000, pitch: 0, roll: 0});
        send_sample('{fz: 0, fy: 16'sh7fff, fx: 0, pitch: 0, roll: 0});
        send_sample('{fz: 0, fy: 16'sh8000, fx: 0, pitch: 0, roll: 0});
        send_sample('{fz: 16'sh7fff, fy: 0, fx: 0, pitch: 16'sd12868, roll: 0});
        send_sample('{fz: 16'sh8000, fy: 0, fx: 0, pitch: 0, roll: 16'sd12868});
        // Just off due north on either side, near the wrap at a full turn, and just off due south.
        send_sample('{fz: 0, fy: 16'sd1, fx: 16'sh7fff, pitch: 0, roll: 0});
        send_sample('{fz: 0, fy: -16'sd1, fx: 16'sh7fff, pitch: 0, roll: 0});
        send_sample('{fz: 0, fy: 16'sd1, fx: 16'sh8000, pitch: 0, roll: 0});
        send_sample('{fz: 0, fy: -16'sd1, fx: 16'sh8000, pitch: 0, roll: 0});
        send_sample('{fz: 16'sh8000, fy: 16'sh8000, fx: 16'sh8000,
                      pitch: 16'sh8000, roll: 16'sh8000});
        go_quiet();
    endtask

    task automatic test_random_with_gaps(int count);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (count) send_sample(rand_sample());
        go_quiet();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so
    // the pipeline fills and its input stalls.
    task automatic test_output_stall(int count);
        tx_idle = 1'b0;
        rx_hold = 300;
        repeat (count) send_sample(rand_sample());
        go_quiet();
    endtask

    // The sender waits until every heading is back before going on.
    task automatic test_drain_pause(int count);
        wait_drained();
        repeat (count) send_sample(rand_sample());
        go_quiet();
    endtask

    task automatic test_back_to_back(int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (count) send_sample(rand_sample());
        go_quiet();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready in random bursts of idling, or held low for a long
    // hold-off when a test asks for one.
    // ------------------------------------------------------------------------
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else if (burst > 0) begin
                m_tready <= 1'b0;
                burst = burst - 1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                burst = $urandom_range(1, 9) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: result %0d got %0d, expected %0d", what, results_seen,
                 got, want);
        errors = errors + 1;
    endtask

    // Results are checked at the falling edge; the handshake then completes at
    // the next rising edge with the same values.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (heading_due.size() == 0) begin
                report_mismatch("unexpected heading", m_tdata, 16'd0);
            end else if (m_tdata !== heading_due[0]) begin
                report_mismatch("heading_angle", m_tdata, heading_due[0]);
                void'(heading_due.pop_front());
            end else begin
                void'(heading_due.pop_front());
            end
            results_seen = results_seen + 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("tilt_compensated_heading_test: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_samples();
        test_random_with_gaps(480);
        test_output_stall(100);
        test_drain_pause(40);
        test_back_to_back(180);
        wait_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (errors == 0 && heading_due.size() == 0) begin
            $display("tilt_compensated_heading_test: done, clean");
        end else begin
            $display("tilt_compensated_heading_test: done, errors");
        end
        $finish;
    end

endmodule
